@@ hdl/vgt_pkg.sv @@
// Shared types and constants for the virtual generic timer register unit.
`timescale 1ns / 1ps
`default_nettype none

package vgt_pkg;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [1:0] SEL_CTL   = 2'd0;
    localparam logic [1:0] SEL_CVAL  = 2'd1;
    localparam logic [1:0] SEL_TVAL  = 2'd2;
    localparam logic [1:0] SEL_OTHER = 2'd3;

    localparam int unsigned CTL_ENABLE_BIT  = 0;
    localparam int unsigned CTL_IMASK_BIT   = 1;
    localparam int unsigned CTL_ISTATUS_BIT = 2;

    localparam logic [63:0] CTL_RESET     = 64'h0000_0000_0000_0002;
    localparam logic [63:0] CVAL_RESET    = 64'h0000_0000_0000_0000;
    localparam logic [63:0] TVAL_DISABLED = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic [63:0] read_data;
        logic        exit_to_user;
        logic        deactivate_irq;
        logic        inject_irq;
        logic        arm_timer;
        logic [63:0] arm_delay;
    } vgt_result_t;

    typedef struct packed {
        logic        ctl_we;
        logic [63:0] ctl_data;
        logic        cmp_we;
        logic [63:0] cmp_data;
    } vgt_update_t;

    function automatic logic fires(input logic [63:0] ctl);
        fires = ctl[CTL_ENABLE_BIT] & ~ctl[CTL_IMASK_BIT];
    endfunction

endpackage

`default_nettype wire

@@ hdl/vgt_access.sv @@
// Combinational decode of one register access into a result and a state update.
`timescale 1ns / 1ps
`default_nettype none

module vgt_access
    import vgt_pkg::*;
(
    input  wire logic        opcode,
    input  wire logic [1:0]  reg_select,
    input  wire logic [63:0] write_data,
    input  wire logic [63:0] counter_now,
    input  wire logic [63:0] ctl_cur,
    input  wire logic [63:0] cmp_cur,
    output vgt_result_t      result,
    output vgt_update_t      update
);

    logic [63:0] tval_sext;
    logic [63:0] cmp_src;
    logic [64:0] diff_wide;
    logic [64:0] sum_wide;
    logic        is_tval_wr;
    logic        lt_now;
    logic [63:0] delay_val;
    logic        was_on;
    logic        new_on;
    logic        turn_on;
    logic        turn_off;
    logic        cmp_written;

    assign tval_sext  = {{32{write_data[31]}}, write_data[31:0]};
    assign cmp_src    = (opcode == OP_WRITE && reg_select == SEL_CVAL) ? write_data : cmp_cur;
    assign diff_wide  = {1'b0, cmp_src} - {1'b0, counter_now};
    assign sum_wide   = {1'b0, tval_sext} + {1'b0, counter_now};
    assign is_tval_wr = (opcode == OP_WRITE) && (reg_select == SEL_TVAL);

    // For a timer value write the new compare is below the counter exactly when
    // the sign-extended addition carries out, and the delay is the written value.
    assign lt_now    = is_tval_wr ? sum_wide[64] : diff_wide[64];
    assign delay_val = is_tval_wr ? tval_sext : diff_wide[63:0];

    assign was_on      = fires(ctl_cur);
    assign new_on      = fires(write_data);
    assign turn_on     = (reg_select == SEL_CTL) && !was_on && new_on;
    assign turn_off    = (reg_select == SEL_CTL) && was_on && !new_on;
    assign cmp_written = (reg_select == SEL_CVAL) || (reg_select == SEL_TVAL);

    always_comb
    begin
        result          = '0;
        update          = '0;
        update.ctl_data = write_data;
        update.ctl_data[CTL_ISTATUS_BIT] = 1'b0;
        update.cmp_data = is_tval_wr ? sum_wide[63:0] : write_data;

        if (reg_select == SEL_OTHER)
        begin
            result.exit_to_user = 1'b1;
        end
        else if (opcode == OP_READ)
        begin
            unique case (reg_select)
                SEL_CTL:
                begin
                    result.read_data = ctl_cur;
                    result.read_data[CTL_ISTATUS_BIT] = ctl_cur[CTL_ISTATUS_BIT] | diff_wide[64];
                end
                SEL_CVAL:
                begin
                    result.read_data = cmp_cur;
                end
                SEL_TVAL:
                begin
                    result.read_data = ctl_cur[CTL_ENABLE_BIT] ? diff_wide[63:0] : TVAL_DISABLED;
                end
                default:
                begin
                    result.read_data = '0;
                end
            endcase
        end
        else
        begin
            update.ctl_we = (reg_select == SEL_CTL);
            update.cmp_we = cmp_written;
            if (turn_on || (cmp_written && was_on))
            begin
                result.deactivate_irq = cmp_written;
                if (lt_now)
                begin
                    result.inject_irq = 1'b1;
                end
                else
                begin
                    result.arm_timer = 1'b1;
                    result.arm_delay = delay_val;
                end
            end
            else if (turn_off)
            begin
                result.deactivate_irq = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/virtual_generic_timer_regs_unit.sv @@
// Top level of the virtual generic timer register unit: request and result registers, state.
//
// Channel  Handshake             Payload
// in       in_valid / in_ready   opcode, reg_select, write_data, counter_now
// out      out_valid / out_ready read_data, exit_to_user, deactivate_irq,
//                                inject_irq, arm_timer, arm_delay
//
// A request is taken into the request register, decoded against the control and compare
// registers, and its result lands in the result register. One request per cycle is
// sustained while the output is not stalled. The control and compare registers change
// when the request leaves the request register, so the next request sees them at once.
// Reset sets the control word to IMASK only and clears the compare value.
// A stalled result holds the result register; an empty request register takes one more.
`timescale 1ns / 1ps
`default_nettype none

module virtual_generic_timer_regs_unit
    import vgt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        opcode,
    input  wire logic [1:0]  reg_select,
    input  wire logic [63:0] write_data,
    input  wire logic [63:0] counter_now,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [63:0]      read_data,
    output logic             exit_to_user,
    output logic             deactivate_irq,
    output logic             inject_irq,
    output logic             arm_timer,
    output logic [63:0]      arm_delay
);

    logic        req_valid_reg;
    logic        req_opcode_reg;
    logic [1:0]  req_select_reg;
    logic [63:0] req_wdata_reg;
    logic [63:0] req_now_reg;
    logic        out_valid_reg;
    vgt_result_t res_reg;
    logic [63:0] ctl_reg;
    logic [63:0] cmp_reg;

    logic        advance;
    logic        take_in;
    vgt_result_t res_next;
    vgt_update_t upd;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !req_valid_reg || advance;
    assign take_in  = in_valid && in_ready;

    vgt_access u_access (
        .opcode      (req_opcode_reg),
        .reg_select  (req_select_reg),
        .write_data  (req_wdata_reg),
        .counter_now (req_now_reg),
        .ctl_cur     (ctl_reg),
        .cmp_cur     (cmp_reg),
        .result      (res_next),
        .update      (upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            ctl_reg       <= CTL_RESET;
            cmp_reg       <= CVAL_RESET;
        end
        else
        begin
            if (in_ready)
            begin
                req_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= req_valid_reg;
            end
            if (req_valid_reg && advance)
            begin
                if (upd.ctl_we)
                begin
                    ctl_reg <= upd.ctl_data;
                end
                if (upd.cmp_we)
                begin
                    cmp_reg <= upd.cmp_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            req_opcode_reg <= opcode;
            req_select_reg <= reg_select;
            req_wdata_reg  <= write_data;
            req_now_reg    <= counter_now;
        end
        if (req_valid_reg && advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_data      = res_reg.read_data;
    assign exit_to_user   = res_reg.exit_to_user;
    assign deactivate_irq = res_reg.deactivate_irq;
    assign inject_irq     = res_reg.inject_irq;
    assign arm_timer      = res_reg.arm_timer;
    assign arm_delay      = res_reg.arm_delay;

`ifndef NO_ASSERTIONS
    a_istatus_never_stored: assert property (@(posedge clk) disable iff (!rst_n)
        ctl_reg[CTL_ISTATUS_BIT] == 1'b0)
        else $error("ISTATUS bit was stored in the control register");

    a_exit_is_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && exit_to_user |-> read_data == '0 && !deactivate_irq && !inject_irq
            && !arm_timer)
        else $error("unknown register access produced side effects");

    a_inject_or_arm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(inject_irq && arm_timer))
        else $error("inject and arm both requested");

    a_delay_only_armed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !arm_timer |-> arm_delay == '0)
        else $error("arm delay nonzero without arm");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request refused while result register is empty");

    a_state_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(ctl_reg) && $stable(cmp_reg))
        else $error("timer state changed while result stalled");
`endif

endmodule

`default_nettype wire

@@ tb/virtual_generic_timer_regs_unit_tb.sv @@
// Testbench for the virtual generic timer register unit with a self-checking scoreboard.
`timescale 1ns / 1ps

module virtual_generic_timer_regs_unit_tb;
    import vgt_pkg::*;

    class timer_regs_scoreboard;
        logic [63:0] ctl_word;
        logic [63:0] cmp_value;
        vgt_result_t answers_due[$];
        int unsigned mismatches;
        int unsigned reads_seen;
        int unsigned writes_seen;
        int unsigned exits_seen;
        int unsigned injects_seen;
        int unsigned arms_seen;
        int unsigned withdrawals_seen;

        function new();
            ctl_word = CTL_RESET;
            cmp_value = CVAL_RESET;
            mismatches = 0;
            reads_seen = 0;
            writes_seen = 0;
            exits_seen = 0;
            injects_seen = 0;
            arms_seen = 0;
            withdrawals_seen = 0;
        endfunction

        function int unsigned pending();
            return answers_due.size();
        endfunction

        static function logic timer_live(logic [63:0] ctl);
            return ctl[CTL_ENABLE_BIT] && !ctl[CTL_IMASK_BIT];
        endfunction

        function void note_access(logic op, logic [1:0] sel, logic [63:0] wdata,
                                  logic [63:0] now);
            vgt_result_t want;
            logic was_live;
            logic now_live;
            logic turned_on;
            logic turned_off;
            logic cmp_moved;
            want = '0;
            turned_on = 1'b0;
            turned_off = 1'b0;
            cmp_moved = 1'b0;
            was_live = timer_live(ctl_word);
            if (sel == SEL_OTHER)
            begin
                want.exit_to_user = 1'b1;
                exits_seen++;
            end
            else if (op == OP_READ)
            begin
                reads_seen++;
                case (sel)
                    SEL_CTL:
                    begin
                        want.read_data = ctl_word;
                        if (cmp_value < now)
                            want.read_data[CTL_ISTATUS_BIT] = 1'b1;
                    end
                    SEL_CVAL:
                        want.read_data = cmp_value;
                    default:
                        want.read_data = ctl_word[CTL_ENABLE_BIT] ? cmp_value - now
                                                                   : TVAL_DISABLED;
                endcase
            end
            else
            begin
                writes_seen++;
                case (sel)
                    SEL_CTL:
                    begin
                        now_live = timer_live(wdata);
                        turned_on = !was_live && now_live;
                        turned_off = was_live && !now_live;
                        ctl_word = wdata;
                        ctl_word[CTL_ISTATUS_BIT] = 1'b0;
                    end
                    SEL_CVAL:
                    begin
                        cmp_moved = 1'b1;
                        cmp_value = wdata;
                    end
                    default:
                    begin
                        cmp_moved = 1'b1;
                        cmp_value = {{32{wdata[31]}}, wdata[31:0]} + now;
                    end
                endcase
                if (turned_on || (cmp_moved && was_live))
                begin
                    want.deactivate_irq = cmp_moved;
                    if (cmp_value < now)
                        want.inject_irq = 1'b1;
                    else
                    begin
                        want.arm_timer = 1'b1;
                        want.arm_delay = cmp_value - now;
                    end
                end
                else if (turned_off)
                    want.deactivate_irq = 1'b1;
            end
            injects_seen += 32'(want.inject_irq);
            arms_seen += 32'(want.arm_timer);
            withdrawals_seen += 32'(want.deactivate_irq);
            answers_due.push_back(want);
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (want !== got)
            begin
                mismatches++;
                $display("%0t: %s expected %h, got %h", $time, field, want, got);
            end
        endfunction

        function void check_answer(vgt_result_t got);
            vgt_result_t want;
            if (answers_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none, got read_data %h exit %b",
                         $time, got.read_data, got.exit_to_user);
                return;
            end
            want = answers_due.pop_front();
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("exit_to_user", 64'(want.exit_to_user), 64'(got.exit_to_user));
            compare_field("deactivate_irq", 64'(want.deactivate_irq),
                          64'(got.deactivate_irq));
            compare_field("inject_irq", 64'(want.inject_irq), 64'(got.inject_irq));
            compare_field("arm_timer", 64'(want.arm_timer), 64'(got.arm_timer));
            compare_field("arm_delay", want.arm_delay, got.arm_delay);
        endfunction
    endclass

    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES = 60;
    localparam int unsigned ITEMS_PER_PHASE = 225;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        opcode = OP_READ;
    logic [1:0]  reg_select = SEL_CTL;
    logic [63:0] write_data = '0;
    logic [63:0] counter_now = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] read_data;
    logic        exit_to_user;
    logic        deactivate_irq;
    logic        inject_irq;
    logic        arm_timer;
    logic [63:0] arm_delay;

    timer_regs_scoreboard sb = new();

    logic [63:0] ticks = '0;
    int unsigned stall_pct = 0;
    int unsigned hold_asked = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;

    virtual_generic_timer_regs_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .reg_select     (reg_select),
        .write_data     (write_data),
        .counter_now    (counter_now),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_data      (read_data),
        .exit_to_user   (exit_to_user),
        .deactivate_irq (deactivate_irq),
        .inject_irq     (inject_irq),
        .arm_timer      (arm_timer),
        .arm_delay      (arm_delay)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_asked)
        begin
            hold_served <= hold_asked;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_access(opcode, reg_select, write_data, counter_now);
            if (out_valid && out_ready)
                sb.check_answer('{read_data: read_data, exit_to_user: exit_to_user,
                                  deactivate_irq: deactivate_irq, inject_irq: inject_irq,
                                  arm_timer: arm_timer, arm_delay: arm_delay});
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= QUIET_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("virtual_generic_timer_regs_unit_tb: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_access(logic op, logic [1:0] sel, logic [63:0] wdata,
                               logic [63:0] now);
        in_valid <= 1'b1;
        opcode <= op;
        reg_select <= sel;
        write_data <= wdata;
        counter_now <= now;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic idle_for(int unsigned cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic wait_for_answers();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic random_access();
        int unsigned pick;
        logic op;
        logic [1:0] sel;
        logic [63:0] wdata;
        logic [31:0] offset;
        pick = $urandom_range(99);
        if (pick < 85)
            ticks = ticks + 64'($urandom_range(40));
        else if (pick < 93)
            ticks = rand64();
        else if (pick < 96)
            ticks = '0;
        else
            ticks = '1 - 64'($urandom_range(60));
        pick = $urandom_range(99);
        sel = (pick < 8) ? SEL_OTHER : (pick < 40) ? SEL_CTL : (pick < 70) ? SEL_CVAL : SEL_TVAL;
        op = ($urandom_range(99) < 60) ? OP_WRITE : OP_READ;
        offset = $urandom_range(300) - 150;
        pick = $urandom_range(99);
        if (pick < 20)
            wdata = rand64();
        else
        begin
            case (sel)
                SEL_CTL:
                begin
                    wdata = ($urandom_range(3) == 0) ? rand64() : 64'd0;
                    wdata[2:0] = (pick < 60) ? 3'b001 : 3'($urandom_range(7));
                end
                SEL_TVAL:
                    wdata = {(($urandom_range(1) != 0) ? $urandom() : 32'd0), offset};
                default:
                    wdata = ticks + {{32{offset[31]}}, offset};
            endcase
        end
        send_access(op, sel, wdata, ticks);
    endtask

    initial
    begin
        int unsigned idle_pct;
        idle_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_access(OP_READ, SEL_CTL, '0, '0);
        send_access(OP_READ, SEL_CTL, '0, 64'd5);
        send_access(OP_READ, SEL_CVAL, '0, '1);
        send_access(OP_READ, SEL_TVAL, '1, 64'd7);
        send_access(OP_READ, SEL_OTHER, '1, 64'd7);
        send_access(OP_WRITE, SEL_OTHER, '1, 64'd7);
        send_access(OP_WRITE, SEL_CVAL, 64'd1000, 64'd10);
        send_access(OP_WRITE, SEL_CTL, 64'h5, 64'd10);
        send_access(OP_READ, SEL_CTL, '0, 64'd10);
        send_access(OP_READ, SEL_TVAL, '0, 64'd10);
        send_access(OP_WRITE, SEL_TVAL, 64'hFFFF_FFFF_FFFF_FFF0, 64'd100);
        send_access(OP_READ, SEL_CTL, '0, 64'd100);
        send_access(OP_WRITE, SEL_TVAL, 64'd50, 64'd100);
        send_access(OP_WRITE, SEL_CVAL, 64'd200, 64'd200);
        send_access(OP_WRITE, SEL_CVAL, '1, '0);
        send_access(OP_READ, SEL_TVAL, '0, '1);
        send_access(OP_WRITE, SEL_CTL, 64'h3, 64'd5);
        send_access(OP_READ, SEL_TVAL, '0, 64'd5);
        send_access(OP_WRITE, SEL_CTL, 64'hFFFF_FFFF_FFFF_FFF9, 64'h8000_0000_0000_0000);
        send_access(OP_WRITE, SEL_CTL, '0, 64'd3);
        send_access(OP_WRITE, SEL_CTL, 64'h1, '1);
        send_access(OP_WRITE, SEL_TVAL, 64'h0000_0000_7FFF_FFFF, '1);
        send_access(OP_WRITE, SEL_CVAL, '0, 64'd1);
        send_access(OP_READ, SEL_CTL, '1, 64'd1);

        for (int phase = 0; phase < 4; phase++)
        begin
            wait_for_answers();
            case (phase)
                0:
                begin
                    idle_pct = 0;
                    stall_pct <= 0;
                    hold_asked <= hold_asked + 1;
                end
                1:
                begin
                    idle_pct = 47;
                    stall_pct <= 0;
                end
                2:
                begin
                    idle_pct = 0;
                    stall_pct <= 47;
                end
                default:
                begin
                    idle_pct = 22;
                    stall_pct <= 22;
                end
            endcase
            repeat (ITEMS_PER_PHASE)
            begin
                random_access();
                while ($urandom_range(99) < idle_pct)
                    idle_for(1);
            end
        end

        wait_for_answers();
        repeat (8) @(posedge clk);
        $display("Checked %0d reads, %0d writes and %0d accesses to other registers.",
                 sb.reads_seen, sb.writes_seen, sb.exits_seen);
        $display("Timer actions predicted: %0d injections, %0d arms, %0d withdrawals.",
                 sb.injects_seen, sb.arms_seen, sb.withdrawals_seen);
        if (sb.mismatches == 0)
            $display("virtual_generic_timer_regs_unit_tb: PASS");
        else
            $display("virtual_generic_timer_regs_unit_tb: FAIL");
        $finish;
    end

endmodule

@@ virtual_generic_timer_regs_unit.f @@
hdl/vgt_pkg.sv
hdl/vgt_access.sv
hdl/virtual_generic_timer_regs_unit.sv
tb/virtual_generic_timer_regs_unit_tb.sv
